@@ design/mssct_pkg.sv @@
// Package for the minutes:seconds countdown timer.
// Holds field widths, event codes, register indexes and the item structs.
// No dependencies.
`default_nettype none

package mssct_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 7;
  localparam int unsigned KindW  = 3;
  localparam int unsigned FlashW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;

  localparam logic [MinW-1:0]   MaxMinutes     = 7'd99;
  localparam logic [SecW-1:0]   MaxSeconds     = 6'd59;
  localparam logic [SecW-1:0]   BeepReset      = 6'd3;
  localparam logic [FlashW-1:0] FlashReset     = 4'd3;
  localparam logic [FlashW-1:0] FlashMinTicks  = 4'd2;

  typedef enum logic [KindW-1:0] {
    KIND_TICK   = 3'd0,
    KIND_INC    = 3'd1,
    KIND_DEC    = 3'd2,
    KIND_TOGGLE = 3'd3,
    KIND_START  = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BEEP_LAST_SECONDS = 1'b0,
    CFG_FLASH_TICKS       = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e kind;
    logic  long_press;
  } item_t;

  typedef struct packed {
    logic [SecW-1:0]   beep_last_seconds;
    logic [FlashW-1:0] flash_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SecW-1:0] seconds_shown;
    logic [MinW-1:0] minutes_shown;
    logic            showing_dashes;
    logic            sound_request;
    logic            dot_blinking;
    logic            is_paused;
    logic            focus_on_seconds;
    logic            press_declined;
  } result_t;

endpackage

`default_nettype wire

@@ design/mssct_evt_if.sv @@
// Event channel of the countdown timer: valid/ready plus the event fields.
// Depends on mssct_pkg for widths.
`default_nettype none

interface mssct_evt_if;
  logic                         valid;
  logic                         ready;
  logic [mssct_pkg::KindW-1:0]  kind;
  logic                         long_press;

  modport source (output valid, output kind, output long_press, input ready);
  modport sink   (input valid, input kind, input long_press, output ready);
endinterface

`default_nettype wire

@@ design/mssct_res_if.sv @@
// Result channel of the countdown timer: valid/ready plus the shown fields.
// Depends on mssct_pkg for widths.
`default_nettype none

interface mssct_res_if;
  logic                        valid;
  logic                        ready;
  logic [mssct_pkg::SecW-1:0]  seconds_shown;
  logic [mssct_pkg::MinW-1:0]  minutes_shown;
  logic                        showing_dashes;
  logic                        sound_request;
  logic                        dot_blinking;
  logic                        is_paused;
  logic                        focus_on_seconds;
  logic                        press_declined;

  modport source (
    output valid, output seconds_shown, output minutes_shown, output showing_dashes,
    output sound_request, output dot_blinking, output is_paused,
    output focus_on_seconds, output press_declined, input ready
  );
  modport sink (
    input valid, input seconds_shown, input minutes_shown, input showing_dashes,
    input sound_request, input dot_blinking, input is_paused,
    input focus_on_seconds, input press_declined, output ready
  );
endinterface

`default_nettype wire

@@ design/mssct_cfg_if.sv @@
// Configuration write channel of the countdown timer: valid/ready, index, data.
// Depends on mssct_pkg for widths.
`default_nettype none

interface mssct_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mssct_pkg::CfgIdxW-1:0]  index;
  logic [mssct_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/mssct_in_reg.sv @@
// Input register of the countdown timer: captures one event item.
// Depends on mssct_pkg and mssct_evt_if.
`default_nettype none

module mssct_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  mssct_evt_if.sink           evt_i,
  input  wire logic           take_i,
  output logic                item_valid_o,
  output mssct_pkg::item_t    item_o
);

  logic             valid_q;
  logic             valid_d;
  mssct_pkg::item_t item_q;

  // The slot frees up in the same cycle the engine takes the held item.
  assign evt_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (evt_i.valid && evt_i.ready) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      item_q.kind       <= mssct_pkg::kind_e'(evt_i.kind);
      item_q.long_press <= evt_i.long_press;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

@@ design/mssct_engine.sv @@
// Timer state and its update per event, plus the result register.
// Depends on mssct_pkg and mssct_res_if.
`default_nettype none

module mssct_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire mssct_pkg::item_t item_i,
  input  wire mssct_pkg::cfg_t  cfg_i,
  output logic               take_o,
  mssct_res_if.source        res_o
);

  logic [mssct_pkg::SecW-1:0]   remain_sec_q, remain_sec_d;
  logic [mssct_pkg::MinW-1:0]   remain_min_q, remain_min_d;
  logic [mssct_pkg::SecW-1:0]   preset_sec_q, preset_sec_d;
  logic [mssct_pkg::MinW-1:0]   preset_min_q, preset_min_d;
  logic                         paused_q, paused_d;
  logic [mssct_pkg::FlashW-1:0] flash_left_q, flash_left_d;
  logic                         edit_sec_q, edit_sec_d;
  logic                         beep_q, beep_d;
  logic                         blink_q, blink_d;
  logic                         declined;

  logic                         out_valid_q, out_valid_d;
  mssct_pkg::result_t           result_q, result_d;

  logic [mssct_pkg::SecW-1:0]   sec_dec;
  logic [mssct_pkg::FlashW-1:0] flash_eff;

  assign take_o    = item_valid_i && (!out_valid_q || res_o.ready);
  assign sec_dec   = remain_sec_q - 6'd1;
  assign flash_eff = (cfg_i.flash_ticks < mssct_pkg::FlashMinTicks) ?
                     mssct_pkg::FlashMinTicks : cfg_i.flash_ticks;

  always_comb begin
    remain_sec_d = remain_sec_q;
    remain_min_d = remain_min_q;
    preset_sec_d = preset_sec_q;
    preset_min_d = preset_min_q;
    paused_d     = paused_q;
    flash_left_d = flash_left_q;
    edit_sec_d   = edit_sec_q;
    beep_d       = beep_q;
    blink_d      = blink_q;
    declined     = 1'b0;

    unique case (item_i.kind)
      mssct_pkg::KIND_TICK: begin
        if (!paused_q) begin
          priority if (flash_left_q != '0) begin
            flash_left_d = flash_left_q - 4'd1;
            // Last dash tick: stop and put the preset back on the display.
            if (flash_left_q == 4'd1) begin
              paused_d     = 1'b1;
              blink_d      = 1'b0;
              remain_sec_d = preset_sec_q;
              remain_min_d = preset_min_q;
            end
          end else if (remain_min_q != '0) begin
            if (remain_sec_q == '0) begin
              remain_min_d = remain_min_q - 7'd1;
              remain_sec_d = mssct_pkg::MaxSeconds;
            end else begin
              remain_sec_d = sec_dec;
            end
          end else if (remain_sec_q != '0) begin
            remain_sec_d = sec_dec;
            if (sec_dec <= cfg_i.beep_last_seconds) begin
              beep_d = 1'b1;
            end
          end else begin
            // The tick that finds zero counts as the first dash tick.
            flash_left_d = flash_eff - 4'd1;
          end
        end
      end
      mssct_pkg::KIND_INC, mssct_pkg::KIND_DEC: begin
        if (edit_sec_q) begin
          if (item_i.kind == mssct_pkg::KIND_INC) begin
            if (remain_sec_q < mssct_pkg::MaxSeconds) remain_sec_d = remain_sec_q + 6'd1;
          end else if (remain_sec_q != '0) begin
            remain_sec_d = sec_dec;
          end
        end else begin
          if (item_i.kind == mssct_pkg::KIND_INC) begin
            if (remain_min_q < mssct_pkg::MaxMinutes) remain_min_d = remain_min_q + 7'd1;
          end else if (remain_min_q != '0) begin
            remain_min_d = remain_min_q - 7'd1;
          end
        end
        preset_sec_d = remain_sec_d;
        preset_min_d = remain_min_d;
      end
      mssct_pkg::KIND_TOGGLE: begin
        edit_sec_d = !edit_sec_q;
      end
      mssct_pkg::KIND_START: begin
        edit_sec_d = 1'b0;
        if (item_i.long_press) begin
          if (remain_min_q == preset_min_q && remain_sec_q == preset_sec_q) begin
            declined = 1'b1;
          end else begin
            paused_d     = 1'b1;
            remain_sec_d = preset_sec_q;
            remain_min_d = preset_min_q;
            beep_d       = 1'b0;
            blink_d      = 1'b0;
            flash_left_d = '0;
          end
        end else begin
          paused_d = !paused_q;
          blink_d  = paused_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_d.seconds_shown    = remain_sec_d;
    result_d.minutes_shown    = remain_min_d;
    result_d.showing_dashes   = (flash_left_d != '0);
    result_d.sound_request    = beep_d;
    result_d.dot_blinking     = blink_d;
    result_d.is_paused        = paused_d;
    result_d.focus_on_seconds = edit_sec_d;
    result_d.press_declined   = declined;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_sec_q <= '0;
      remain_min_q <= '0;
      preset_sec_q <= '0;
      preset_min_q <= '0;
      paused_q     <= 1'b1;
      flash_left_q <= '0;
      edit_sec_q   <= 1'b0;
      beep_q       <= 1'b0;
      blink_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        remain_sec_q <= remain_sec_d;
        remain_min_q <= remain_min_d;
        preset_sec_q <= preset_sec_d;
        preset_min_q <= preset_min_d;
        paused_q     <= paused_d;
        flash_left_q <= flash_left_d;
        edit_sec_q   <= edit_sec_d;
        beep_q       <= beep_d;
        blink_q      <= blink_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.seconds_shown    = result_q.seconds_shown;
  assign res_o.minutes_shown    = result_q.minutes_shown;
  assign res_o.showing_dashes   = result_q.showing_dashes;
  assign res_o.sound_request    = result_q.sound_request;
  assign res_o.dot_blinking     = result_q.dot_blinking;
  assign res_o.is_paused        = result_q.is_paused;
  assign res_o.focus_on_seconds = result_q.focus_on_seconds;
  assign res_o.press_declined   = result_q.press_declined;

endmodule

`default_nettype wire

@@ design/minute_second_countdown_timer.sv @@
// Minutes:seconds countdown timer with preset, dash flash at zero and beep flag.
// Path: an accepted event item is held in the input register, then its result
// in the result register. Throughput: one item per cycle while the result side
// is ready; the state update for an item finishes in the cycle it leaves the input register.
// Reset: count and preset 0:00, paused, minutes focus, flags clear,
// beep threshold 3 seconds, flash length 3 ticks.
`default_nettype none

module minute_second_countdown_timer (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mssct_evt_if.sink    evt_i,
  mssct_cfg_if.sink    cfg_i,
  mssct_res_if.source  res_o
);

  mssct_pkg::cfg_t  cfg_q;
  mssct_pkg::item_t item;
  logic             item_valid;
  logic             take;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beep_last_seconds <= mssct_pkg::BeepReset;
      cfg_q.flash_ticks       <= mssct_pkg::FlashReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (mssct_pkg::cfg_idx_e'(cfg_i.index))
        mssct_pkg::CFG_BEEP_LAST_SECONDS: cfg_q.beep_last_seconds <= cfg_i.data;
        mssct_pkg::CFG_FLASH_TICKS: cfg_q.flash_ticks <= cfg_i.data[mssct_pkg::FlashW-1:0];
      endcase
    end
  end

  mssct_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mssct_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .take_o       (take),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire
